[sv/sfcc_pkg.sv]
// Package with the constants and the CRC-8 byte update of the sensor frame checker.
`default_nettype none

package sfcc_pkg;

  localparam logic [7:0]  CrcInit      = 8'hFF;
  localparam logic [7:0]  CrcPoly      = 8'h31;
  localparam logic [3:0]  LastPosition = 4'd8;
  localparam logic [14:0] TempScale    = 15'd17500;
  localparam logic [14:0] TempOffset   = 15'd4500;
  localparam logic [13:0] HumScale     = 14'd10000;

  typedef logic [3:0] pos_t;

  function automatic logic [7:0] crc8_feed(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] acc;
    acc = crc ^ data;
    for (int k = 0; k < 8; k++) begin
      if (acc[7]) begin
        acc = {acc[6:0], 1'b0} ^ CrcPoly;
      end else begin
        acc = {acc[6:0], 1'b0};
      end
    end
    return acc;
  endfunction

endpackage

`default_nettype wire

[sv/sfcc_if.sv]
// Valid/ready channel interfaces for the received bytes and the checked results.
`default_nettype none

interface sfcc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       frame_start;

  modport source (output valid, output rx_byte, output frame_start, input ready);
  modport sink   (input valid, input rx_byte, input frame_start, output ready);
endinterface

interface sfcc_out_if;
  logic               valid;
  logic               ready;
  logic               status;
  logic [15:0]        co2_ppm;
  logic signed [14:0] temp_centi;
  logic [13:0]        hum_centi;

  modport source (output valid, output status, output co2_ppm, output temp_centi,
                  output hum_centi, input ready);
  modport sink   (input valid, input status, input co2_ppm, input temp_centi,
                  input hum_centi, output ready);
endinterface

`default_nettype wire

[sv/sensor_frame_crc_check_scale.sv]
// Top level: checks the word CRCs of a nine-byte measurement reply and scales the values.
`default_nettype none

// The block takes one byte of the reply per clock cycle, back to back. Each of the
// three words (CO2, temperature, humidity) is sent high byte first and followed by a
// CRC-8 (polynomial 0x31, start 0xFF) that restarts for every word. A high frame_start
// makes that beat byte zero of a new reply. The ninth byte produces one result beat,
// registered, in the cycle after that byte is taken: status is zero when all three CRCs
// matched and the stored values were refreshed, one when they were held. The CRC of a
// byte is combinational logic and each scaling uses a single constant multiplier fed
// from the word registers. The only stall is a byte offered at the ninth position of a
// reply while the previous result is still waiting to be taken; a byte that carries
// frame_start at that position waits as well.
module sensor_frame_crc_check_scale
  import sfcc_pkg::*;
(
  input  wire            clk_i,
  input  wire            rst_ni,
  sfcc_in_if.sink        in_i,
  sfcc_out_if.source     out_o
);

  pos_t               pos_q, pos_d;
  logic [7:0]         crc_q, crc_d;
  logic [7:0]         high_q, high_d;
  logic [15:0]        co2_word_q, co2_word_d;
  logic [15:0]        temp_word_q, temp_word_d;
  logic [15:0]        hum_word_q, hum_word_d;
  logic               bad_q, bad_d;
  logic               status_q, status_d;
  logic [15:0]        good_co2_q, good_co2_d;
  logic signed [14:0] good_temp_q, good_temp_d;
  logic [13:0]        good_hum_q, good_hum_d;
  logic               out_valid_q, out_valid_d;

  logic               accept;
  pos_t               pos_eff;
  logic               bad_base;
  logic               load;
  logic [30:0]        temp_prod;
  logic [29:0]        hum_prod;

  assign in_i.ready = (pos_q != LastPosition) || !out_valid_q || out_o.ready;
  assign accept     = in_i.valid && in_i.ready;

  assign temp_prod = 31'(TempScale) * 31'(temp_word_q);
  assign hum_prod  = 30'(HumScale) * 30'(hum_word_q);

  always_comb begin
    pos_eff     = in_i.frame_start ? '0 : pos_q;
    bad_base    = (pos_eff == '0) ? 1'b0 : bad_q;
    pos_d       = pos_q;
    crc_d       = crc_q;
    high_d      = high_q;
    co2_word_d  = co2_word_q;
    temp_word_d = temp_word_q;
    hum_word_d  = hum_word_q;
    bad_d       = bad_q;
    status_d    = status_q;
    good_co2_d  = good_co2_q;
    good_temp_d = good_temp_q;
    good_hum_d  = good_hum_q;
    load        = 1'b0;
    if (accept) begin
      bad_d = bad_base;
      if (pos_eff inside {4'd0, 4'd3, 4'd6}) begin
        crc_d  = crc8_feed(CrcInit, in_i.rx_byte);
        high_d = in_i.rx_byte;
      end else if (pos_eff inside {4'd1, 4'd4, 4'd7}) begin
        crc_d = crc8_feed(crc_q, in_i.rx_byte);
        case (pos_eff)
          4'd1:    co2_word_d  = {high_q, in_i.rx_byte};
          4'd4:    temp_word_d = {high_q, in_i.rx_byte};
          default: hum_word_d  = {high_q, in_i.rx_byte};
        endcase
      end else begin
        crc_d = CrcInit;
        bad_d = bad_base || (crc_q != in_i.rx_byte);
      end
      if (pos_eff == LastPosition) begin
        pos_d    = '0;
        load     = 1'b1;
        status_d = bad_d;
        if (!bad_d) begin
          good_co2_d  = co2_word_q;
          good_temp_d = $signed(temp_prod[30:16] - TempOffset);
          good_hum_d  = hum_prod[29:16];
        end
      end else begin
        pos_d = pos_eff + 4'd1;
      end
    end
    out_valid_d = load ? 1'b1 : (out_o.ready ? 1'b0 : out_valid_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      crc_q       <= CrcInit;
      high_q      <= '0;
      co2_word_q  <= '0;
      temp_word_q <= '0;
      hum_word_q  <= '0;
      bad_q       <= 1'b0;
      status_q    <= 1'b0;
      good_co2_q  <= '0;
      good_temp_q <= '0;
      good_hum_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      pos_q       <= pos_d;
      crc_q       <= crc_d;
      high_q      <= high_d;
      co2_word_q  <= co2_word_d;
      temp_word_q <= temp_word_d;
      hum_word_q  <= hum_word_d;
      bad_q       <= bad_d;
      status_q    <= status_d;
      good_co2_q  <= good_co2_d;
      good_temp_q <= good_temp_d;
      good_hum_q  <= good_hum_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.status     = status_q;
  assign out_o.co2_ppm    = good_co2_q;
  assign out_o.temp_centi = good_temp_q;
  assign out_o.hum_centi  = good_hum_q;

endmodule

`default_nettype wire

[sv/sfcc_checker.sv]
// Port-level assertions for the sensor frame checker and their bind to the top level.
`default_nettype none

module sfcc_checker (
  input wire               clk_i,
  input wire               rst_ni,
  input wire               in_valid_i,
  input wire               in_ready_i,
  input wire               out_valid_i,
  input wire               out_ready_i,
  input wire               status_i,
  input wire [15:0]        co2_ppm_i,
  input wire signed [14:0] temp_centi_i,
  input wire [13:0]        hum_centi_i
);

  // A waiting result beat keeps its payload until it is taken.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable({status_i, co2_ppm_i, temp_centi_i, hum_centi_i}))
    else $error("result beat changed while stalled");

  // A result only follows an accepted byte.
  a_out_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(in_valid_i && in_ready_i))
    else $error("result beat without an accepted byte");

  // With no result waiting the input side is never stalled.
  a_no_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i |-> in_ready_i)
    else $error("input stalled with an empty output");

  // Scaled values stay within the physical ranges.
  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (temp_centi_i >= -15'sd4500) && (temp_centi_i <= 15'sd12999)
                    && (hum_centi_i <= 14'd9999))
    else $error("scaled value out of range");

endmodule

bind sensor_frame_crc_check_scale sfcc_checker u_sfcc_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .status_i     (out_o.status),
  .co2_ppm_i    (out_o.co2_ppm),
  .temp_centi_i (out_o.temp_centi),
  .hum_centi_i  (out_o.hum_centi)
);

`default_nettype wire

[tb/sv/sfcc_tb_pkg.sv]
// Scoreboard package: predicts the checked readings of the sensor frame checker and compares them.
package sfcc_tb_pkg;
  import sfcc_pkg::*;

  typedef struct {
    logic               status;
    logic [15:0]        co2_ppm;
    logic signed [14:0] temp_centi;
    logic [13:0]        hum_centi;
  } reading_t;

  function automatic logic [7:0] word_crc_byte(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] c;
    c = crc ^ data;
    repeat (8) begin
      c = c[7] ? ((c << 1) ^ CrcPoly) : (c << 1);
    end
    return c;
  endfunction

  class frame_scoreboard;
    pos_t       next_pos;
    logic [7:0] word_crc;
    logic [7:0] high_byte;
    logic [15:0] co2_raw;
    logic [15:0] temp_word;
    logic [15:0] hum_raw;
    logic       frame_bad;
    logic [15:0] good_co2;
    logic signed [14:0] good_temp;
    logic [13:0] good_hum;
    reading_t   expected_q[$];
    int         errors;

    function new();
      next_pos  = '0;
      word_crc  = CrcInit;
      high_byte = '0;
      co2_raw   = '0;
      temp_word = '0;
      hum_raw   = '0;
      frame_bad = 1'b0;
      good_co2  = '0;
      good_temp = '0;
      good_hum  = '0;
      errors    = 0;
    endfunction

    function void note_byte(input logic [7:0] rx_byte, input logic frame_start);
      pos_t     pos;
      int       t_val;
      int       h_val;
      reading_t r;
      pos = frame_start ? pos_t'(0) : next_pos;
      if (pos > LastPosition) pos = '0;
      if (pos == 0) frame_bad = 1'b0;
      case (pos)
        4'd0, 4'd3, 4'd6: begin
          word_crc  = word_crc_byte(CrcInit, rx_byte);
          high_byte = rx_byte;
        end
        4'd1, 4'd4, 4'd7: begin
          word_crc = word_crc_byte(word_crc, rx_byte);
          if (pos == 1) co2_raw = {high_byte, rx_byte};
          else if (pos == 4) temp_word = {high_byte, rx_byte};
          else hum_raw = {high_byte, rx_byte};
        end
        default: begin
          if (word_crc != rx_byte) frame_bad = 1'b1;
          word_crc = CrcInit;
        end
      endcase
      if (pos == LastPosition) begin
        next_pos = '0;
        if (!frame_bad) begin
          t_val     = (int'(TempScale) * int'(temp_word)) >>> 16;
          h_val     = (int'(HumScale) * int'(hum_raw)) >>> 16;
          good_co2  = co2_raw;
          good_temp = 15'(t_val - int'(TempOffset));
          good_hum  = 14'(h_val);
        end
        r.status     = frame_bad;
        r.co2_ppm    = good_co2;
        r.temp_centi = good_temp;
        r.hum_centi  = good_hum;
        expected_q.push_back(r);
      end else begin
        next_pos = pos + 1'b1;
      end
    endfunction

    function void check_reading(input reading_t got);
      reading_t want;
      if (expected_q.size() == 0) begin
        $error("result beat arrived with no reading expected");
        errors++;
        return;
      end
      want = expected_q.pop_front();
      if (got.status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, got.status);
        errors++;
      end
      if (got.co2_ppm !== want.co2_ppm) begin
        $error("co2_ppm: expected %0d, got %0d", want.co2_ppm, got.co2_ppm);
        errors++;
      end
      if (got.temp_centi !== want.temp_centi) begin
        $error("temp_centi: expected %0d, got %0d", want.temp_centi, got.temp_centi);
        errors++;
      end
      if (got.hum_centi !== want.hum_centi) begin
        $error("hum_centi: expected %0d, got %0d", want.hum_centi, got.hum_centi);
        errors++;
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

endpackage

[tb/sv/tb.sv]
// Top-level testbench: drives measurement replies into the frame checker and checks every reading.
module tb;
  import sfcc_pkg::*;
  import sfcc_tb_pkg::*;

  localparam int CycleLimit   = 400000;
  localparam int ByteTarget   = 1700;
  localparam int HoldOffStart = 500;
  localparam int HoldOffLen   = 300;

  logic clk;
  logic rst_n;

  sfcc_in_if  in_if ();
  sfcc_out_if out_if ();

  sensor_frame_crc_check_scale i_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  frame_scoreboard sb;
  int  n_sent;
  int  cycles;
  bit  tx_calm;
  bit  rx_calm;
  int  stall_left;
  int  hold_left;
  bit  hold_done;

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    in_if.valid = 1'b0;
    in_if.rx_byte = '0;
    in_if.frame_start = 1'b0;
    out_if.ready = 1'b0;
  end

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic int pick_gap(input bit calm);
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(11, 40);
  endfunction

  function automatic logic [15:0] rand_word();
    case ($urandom_range(0, 9))
      0: return 16'h0000;
      1: return 16'hFFFF;
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic fs);
    int gap;
    gap = pick_gap(tx_calm);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.rx_byte <= b;
    in_if.frame_start <= fs;
    do @(posedge clk); while (in_if.ready !== 1'b1);
    sb.note_byte(b, fs);
    n_sent++;
    @(negedge clk);
  endtask

  task automatic send_word(input logic [15:0] w, input logic fs, input bit corrupt);
    logic [7:0] crc;
    crc = word_crc_byte(word_crc_byte(CrcInit, w[15:8]), w[7:0]);
    if (corrupt) crc = crc ^ 8'($urandom_range(1, 255));
    send_byte(w[15:8], fs);
    send_byte(w[7:0], 1'b0);
    send_byte(crc, 1'b0);
  endtask

  task automatic send_reply(input logic fs, input logic [2:0] bad_words);
    send_word(rand_word(), fs, bad_words[0]);
    send_word(rand_word(), 1'b0, bad_words[1]);
    send_word(rand_word(), 1'b0, bad_words[2]);
  endtask

  always @(negedge clk) begin
    if (rst_n) begin
      if ($urandom_range(0, 99) == 0) rx_calm = !rx_calm;
      if (!hold_done && n_sent >= HoldOffStart) begin
        hold_done = 1'b1;
        hold_left = HoldOffLen;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
        if ($urandom_range(0, 99) < 25) stall_left = pick_gap(rx_calm);
      end
    end
  end

  always @(posedge clk) begin
    reading_t got;
    if (rst_n && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
      got.status     = out_if.status;
      got.co2_ppm    = out_if.co2_ppm;
      got.temp_centi = out_if.temp_centi;
      got.hum_centi  = out_if.hum_centi;
      sb.check_reading(got);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    int r;
    int len;
    sb = new();
    n_sent = 0;
    cycles = 0;
    tx_calm = 1'b0;
    rx_calm = 1'b0;
    stall_left = 0;
    hold_left = 0;
    hold_done = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // A reply of zero bytes fails its checks, so the reset values come back.
    send_byte(8'h00, 1'b1);
    repeat (8) send_byte(8'h00, 1'b0);
    // A reply cut short by a new frame start.
    send_byte(8'hFF, 1'b1);
    repeat (3) send_byte(8'hFF, 1'b0);
    send_word(16'hFFFF, 1'b1, 1'b0);
    send_word(16'h0000, 1'b0, 1'b0);
    send_word(16'hFFFF, 1'b0, 1'b0);
    // The next reply follows on without a frame start.
    send_word(16'h0000, 1'b0, 1'b0);
    send_word(16'hFFFF, 1'b0, 1'b0);
    send_word(16'h0000, 1'b0, 1'b0);

    while (n_sent < ByteTarget) begin
      if ($urandom_range(0, 7) == 0) tx_calm = !tx_calm;
      r = $urandom_range(0, 99);
      if (r < 80) begin
        send_reply($urandom_range(0, 3) != 0,
                   ($urandom_range(0, 3) == 0) ? 3'($urandom_range(1, 7)) : 3'b000);
      end else if (r < 90) begin
        len = $urandom_range(1, 8);
        send_byte(8'($urandom_range(0, 255)), 1'b1);
        repeat (len - 1) send_byte(8'($urandom_range(0, 255)), 1'b0);
      end else begin
        len = $urandom_range(1, 12);
        repeat (len) send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 9) == 0);
      end
    end
    in_if.valid <= 1'b0;

    while (sb.pending() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
